// ===== src/mfpe_pkg.sv =====
// ----------------------------------------------------------------------------
// mfpe_pkg
// shared types and constants of the monochrome frame buffer pixel engine
// ----------------------------------------------------------------------------
package mfpe_pkg;

  localparam int unsigned ChipColumns = 64;
  localparam int unsigned ChipColBits = $clog2(ChipColumns);

  localparam logic [7:0] CmdPageBase   = 8'hB8;
  localparam logic [7:0] CmdColumnBase = 8'h40;
  localparam logic [7:0] PixelMaskBase = 8'h01;
  localparam logic [7:0] PixelKeepBase = 8'hFE;

  localparam logic ModePut = 1'b0;
  localparam logic ModeGet = 1'b1;

  typedef struct packed {
    logic       mode;
    logic [7:0] x_coord;
    logic [6:0] y_coord;
    logic       pixel_on;
  } mfpe_req_t;

  typedef struct packed {
    logic [1:0] chip_index;
    logic       is_data;
    logic [7:0] bus_byte;
    logic       pixel_read;
    logic       last;
  } mfpe_rsp_t;

  typedef enum logic [3:0] {
    StIdle = 4'b0001,
    StRead = 4'b0010,
    StCol  = 4'b0100,
    StData = 4'b1000
  } mfpe_state_e;

endpackage

// ===== src/monochrome_framebuffer_pixel_engine.sv =====
// ----------------------------------------------------------------------------
// monochrome_framebuffer_pixel_engine
// page-organized one-bit frame store with panel write-through beats
// ----------------------------------------------------------------------------
// After reset the frame store is zero-filled one byte per cycle, sweeping all
// PANEL_PAGES * PANEL_COLUMNS bytes (1536 by default); busy stays high
// throughout. A get reads the store, then registers one result. A put
// reads the byte, writes it back modified in the next cycle and, with
// update_enable set, emits page, column and data beats on successive
// cycles; the next request is taken in the cycle that shows the column beat,
// so a new put can be accepted before the data beat of the last one is out.
// Results are strobed for one cycle and cannot be stalled.
module monochrome_framebuffer_pixel_engine #(
  parameter int unsigned PANEL_COLUMNS = 192,
  parameter int unsigned PANEL_PAGES   = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  mfpe_pkg::mfpe_req_t req_i,
  output logic              strobe_o,
  output mfpe_pkg::mfpe_rsp_t rsp_o,
  input  logic              cfg_we_i,
  input  logic              cfg_wdata_i
);

  import mfpe_pkg::*;

  localparam int unsigned Depth = PANEL_PAGES * PANEL_COLUMNS;
  localparam int unsigned AddrW = $clog2(Depth);

  mfpe_state_e state_q, state_d;

  logic             update_enable_q;
  logic             accept;
  logic             clearing;
  logic             on_panel;
  logic [3:0]       page;
  logic [AddrW-1:0] addr;
  logic [7:0]       rd_data;
  logic [7:0]       new_byte;
  logic             wr_en;

  logic             mode_q;
  logic             on_q;
  logic             inside_q;
  logic [3:0]       page_q;
  logic [7:0]       x_q;
  logic [7:0]       mask_q;
  logic [AddrW-1:0] addr_q;
  logic [7:0]       byte_q, byte_d;

  logic             strobe_q, strobe_d;
  mfpe_rsp_t        rsp_q, rsp_d;

  assign busy   = clearing | (state_q == StRead) | (state_q == StCol);
  assign accept = start & ~busy;

  assign on_panel = (9'(req_i.x_coord) < 9'(PANEL_COLUMNS)) &&
                    (8'(req_i.y_coord) < 8'(8 * PANEL_PAGES));
  assign page   = req_i.y_coord[6:3];
  assign addr   = AddrW'(32'(page) * PANEL_COLUMNS + 32'(req_i.x_coord));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      update_enable_q <= 1'b1;
    end else if (cfg_we_i) begin
      update_enable_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q   <= req_i.mode;
      on_q     <= req_i.pixel_on;
      inside_q <= on_panel;
      page_q   <= page;
      x_q      <= req_i.x_coord;
      mask_q   <= PixelMaskBase << req_i.y_coord[2:0];
      addr_q   <= addr;
    end
    byte_q <= byte_d;
    rsp_q  <= rsp_d;
  end

  assign new_byte = on_q ? (rd_data | mask_q) : (rd_data & ~mask_q);
  assign wr_en    = (state_q == StRead) && (mode_q == ModePut) && inside_q;

  always_comb begin
    state_d  = state_q;
    strobe_d = 1'b0;
    rsp_d    = rsp_q;
    byte_d   = byte_q;
    case (state_q)
      StIdle: begin
        if (accept) begin
          state_d = StRead;
        end
      end
      StRead: begin
        state_d = StIdle;
        if (mode_q == ModeGet) begin
          strobe_d         = 1'b1;
          rsp_d            = '0;
          rsp_d.pixel_read = inside_q & (|(rd_data & mask_q));
          rsp_d.last       = 1'b1;
        end else if (inside_q && update_enable_q) begin
          state_d          = StCol;
          byte_d           = new_byte;
          strobe_d         = 1'b1;
          rsp_d.chip_index = 2'(x_q / ChipColumns);
          rsp_d.is_data    = 1'b0;
          rsp_d.bus_byte   = CmdPageBase + 8'(page_q);
          rsp_d.pixel_read = 1'b0;
          rsp_d.last       = 1'b0;
        end
      end
      StCol: begin
        state_d        = StData;
        strobe_d       = 1'b1;
        rsp_d.bus_byte = CmdColumnBase + 8'(x_q[ChipColBits-1:0]);
      end
      StData: begin
        state_d        = accept ? StRead : StIdle;
        strobe_d       = 1'b1;
        rsp_d.is_data  = 1'b1;
        rsp_d.bus_byte = byte_q;
        rsp_d.last     = 1'b1;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      strobe_q <= strobe_d;
    end
  end

  mfpe_store #(
    .Depth (Depth),
    .AddrW (AddrW)
  ) u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (accept & on_panel),
    .rd_addr_i  (addr),
    .rd_data_o  (rd_data),
    .wr_en_i    (wr_en),
    .wr_addr_i  (addr_q),
    .wr_data_i  (new_byte),
    .clearing_o (clearing)
  );

  assign strobe_o = strobe_q;
  assign rsp_o    = rsp_q;

  // request goes straight to the store read
  a_accept_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == StRead)
    else $error("accepted request did not enter read");

  // page beat is on the bus while the column beat is prepared
  a_page_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StCol |-> strobe_o && !rsp_o.is_data && !rsp_o.last)
    else $error("page beat missing");

  // column beat is on the bus while the data beat is prepared
  a_col_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StData |-> strobe_o && !rsp_o.is_data && !rsp_o.last)
    else $error("column beat missing");

  // no request and no result during the zero-fill sweep
  a_clear_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing |-> busy && !strobe_o)
    else $error("activity during store clear");

endmodule

// ===== src/mfpe_store.sv =====
// ----------------------------------------------------------------------------
// mfpe_store
// frame store memory with a registered read and a zero-fill sweep after reset
// ----------------------------------------------------------------------------
module mfpe_store #(
  parameter int unsigned Depth = 1536,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             rd_en_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output logic [7:0]       rd_data_o,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [7:0]       wr_data_i,
  output logic             clearing_o
);

  logic [7:0]       mem [Depth];
  logic [7:0]       rd_data_q;
  logic             clearing_q, clearing_d;
  logic [AddrW-1:0] clr_addr_q, clr_addr_d;
  logic             we;
  logic [AddrW-1:0] waddr;
  logic [7:0]       wdata;

  always_comb begin
    clearing_d = clearing_q;
    clr_addr_d = clr_addr_q;
    if (clearing_q) begin
      clr_addr_d = clr_addr_q + AddrW'(1);
      if (clr_addr_q == AddrW'(Depth - 1)) begin
        clearing_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_addr_q <= '0;
    end else begin
      clearing_q <= clearing_d;
      clr_addr_q <= clr_addr_d;
    end
  end

  assign we    = clearing_q | wr_en_i;
  assign waddr = clearing_q ? clr_addr_q : wr_addr_i;
  assign wdata = clearing_q ? 8'h00 : wr_data_i;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o  = rd_data_q;
  assign clearing_o = clearing_q;

endmodule

// ===== tb/sv/monochrome_framebuffer_pixel_engine_checker.sv =====
// ----------------------------------------------------------------------------
// monochrome_framebuffer_pixel_engine_checker
// Watches the request, result and register ports of the pixel engine. It keeps
// its own copy of the frame store and of update_enable, builds the panel bus
// beats or pixel reads that each accepted request should produce, and compares
// every strobed result, field by field, against the oldest queued beat.
// ----------------------------------------------------------------------------
module monochrome_framebuffer_pixel_engine_checker #(
  parameter int unsigned PANEL_COLUMNS = 192,
  parameter int unsigned PANEL_PAGES   = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  input  logic                busy,
  input  mfpe_pkg::mfpe_req_t req_i,
  input  logic                strobe_i,
  input  mfpe_pkg::mfpe_rsp_t rsp_i,
  input  logic                cfg_we_i,
  input  logic                cfg_wdata_i,
  output int                  fail_count_o,
  output int                  beats_pending_o
);

  import mfpe_pkg::*;

  localparam int unsigned StoreBytes = PANEL_PAGES * PANEL_COLUMNS;

  logic [7:0] pixel_store [StoreBytes];
  logic       write_through;
  mfpe_rsp_t  beat_q [$];
  mfpe_rsp_t  want_beat;
  int         fail_count;

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endtask

  task automatic predict_request(input mfpe_req_t r);
    logic        on_panel;
    int unsigned page;
    int unsigned addr;
    logic [7:0]  mask;
    logic [7:0]  new_byte;
    mfpe_rsp_t   beat;
    on_panel = (r.x_coord < PANEL_COLUMNS) && (r.y_coord < 8 * PANEL_PAGES);
    page     = r.y_coord >> 3;
    addr     = page * PANEL_COLUMNS + r.x_coord;
    mask     = PixelMaskBase << r.y_coord[2:0];
    beat     = '0;
    if (r.mode == ModeGet) begin
      beat.pixel_read = on_panel ? |(pixel_store[addr] & mask) : 1'b0;
      beat.last       = 1'b1;
      beat_q.push_back(beat);
    end else if (on_panel) begin
      new_byte = r.pixel_on ? (pixel_store[addr] | mask) : (pixel_store[addr] & ~mask);
      pixel_store[addr] = new_byte;
      if (write_through) begin
        beat.chip_index = 2'(r.x_coord / ChipColumns);
        beat.bus_byte   = 8'(CmdPageBase + page);
        beat_q.push_back(beat);
        beat.bus_byte   = 8'(CmdColumnBase + (r.x_coord % ChipColumns));
        beat_q.push_back(beat);
        beat.is_data    = 1'b1;
        beat.bus_byte   = new_byte;
        beat.last       = 1'b1;
        beat_q.push_back(beat);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (pixel_store[i]) pixel_store[i] = '0;
      write_through = 1'b1;
      beat_q.delete();
      fail_count = 0;
    end else begin
      if (strobe_i) begin
        if (beat_q.size() == 0) begin
          $error("result with no request outstanding: %p", rsp_i);
          fail_count++;
        end else begin
          want_beat = beat_q.pop_front();
          check_field("chip_index", want_beat.chip_index, rsp_i.chip_index);
          check_field("is_data", want_beat.is_data, rsp_i.is_data);
          check_field("bus_byte", want_beat.bus_byte, rsp_i.bus_byte);
          check_field("pixel_read", want_beat.pixel_read, rsp_i.pixel_read);
          check_field("last", want_beat.last, rsp_i.last);
        end
      end
      if (cfg_we_i) write_through = cfg_wdata_i;
      if (start && !busy) predict_request(req_i);
    end
    fail_count_o    = fail_count;
    beats_pending_o = beat_q.size();
  end

endmodule

// ===== tb/sv/monochrome_framebuffer_pixel_engine_tb.sv =====
// ----------------------------------------------------------------------------
// monochrome_framebuffer_pixel_engine_tb
// Drives the pixel engine with a directed set of corner requests, then with
// phases of random put and get requests under both update_enable settings,
// with random request gaps in some phases. Checking is done by the checker module; this top
// only makes stimulus, runs the watchdog and reports the verdict.
// ----------------------------------------------------------------------------
module monochrome_framebuffer_pixel_engine_tb;

  import mfpe_pkg::*;

  localparam int unsigned PanelColumns = 192;
  localparam int unsigned PanelPages   = 8;
  localparam int          IdleLimit    = 5000;
  localparam int          PhaseItems   = 125;

  logic      clk_i;
  logic      rst_ni;
  logic      start;
  logic      busy;
  mfpe_req_t req_i;
  logic      strobe_o;
  mfpe_rsp_t rsp_o;
  logic      cfg_we_i;
  logic      cfg_wdata_i;
  int        fail_count;
  int        beats_pending;

  int        put_count;
  int        get_count;
  int        off_panel_count;
  int        cfg_count;
  int        idle_cycles;
  bit        gaps_on;
  int        hot_x;
  int        hot_y;

  monochrome_framebuffer_pixel_engine #(
    .PANEL_COLUMNS(PanelColumns),
    .PANEL_PAGES  (PanelPages)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_i      (req_i),
    .strobe_o   (strobe_o),
    .rsp_o      (rsp_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  monochrome_framebuffer_pixel_engine_checker #(
    .PANEL_COLUMNS(PanelColumns),
    .PANEL_PAGES  (PanelPages)
  ) checker_i (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .req_i          (req_i),
    .strobe_i       (strobe_o),
    .rsp_i          (rsp_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .fail_count_o   (fail_count),
    .beats_pending_o(beats_pending)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // no-progress watchdog, also covers the store clear after reset
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((start && !busy) || strobe_o) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("watchdog: no progress for %0d cycles", IdleLimit);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  function automatic bit is_off_panel(input mfpe_req_t r);
    return (r.x_coord >= PanelColumns) || (r.y_coord >= 8 * PanelPages);
  endfunction

  function automatic mfpe_req_t make_request(input logic mode, input int x, input int y,
                                             input logic on);
    mfpe_req_t r;
    r.mode     = mode;
    r.x_coord  = 8'(x);
    r.y_coord  = 7'(y);
    r.pixel_on = on;
    return r;
  endfunction

  function automatic mfpe_req_t random_request();
    mfpe_req_t r;
    int        sel;
    sel        = $urandom_range(0, 9);
    r.mode     = $urandom_range(0, 1) ? ModeGet : ModePut;
    r.pixel_on = 1'($urandom_range(0, 1));
    if (sel < 2) begin
      r.x_coord = 8'($urandom_range(0, 255));
      r.y_coord = 7'($urandom_range(0, 127));
    end else if (sel < 6) begin
      // small window so gets often land on recently written pixels
      r.x_coord = 8'(hot_x + $urandom_range(0, 3));
      r.y_coord = 7'(hot_y + $urandom_range(0, 9));
    end else begin
      r.x_coord = 8'($urandom_range(0, PanelColumns - 1));
      r.y_coord = 7'($urandom_range(0, 8 * PanelPages - 1));
    end
    return r;
  endfunction

  function automatic int random_gap();
    int p;
    p = $urandom_range(0, 99);
    if (!gaps_on || p < 60) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic issue_request(input mfpe_req_t r, input int gap);
    @(negedge clk_i);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy);
    if (r.mode == ModeGet) get_count++;
    else put_count++;
    if (is_off_panel(r)) off_panel_count++;
  endtask

  task automatic end_burst();
    @(negedge clk_i);
    start <= 1'b0;
  endtask

  task automatic wait_drained();
    while (beats_pending != 0) @(negedge clk_i);
    // a put with write-through off leaves no beat but may still be in flight
    repeat (8) @(negedge clk_i);
    while (busy) @(negedge clk_i);
  endtask

  task automatic write_update_enable(input logic value);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    cfg_count++;
  endtask

  task automatic run_random_phase(input logic update, input bit with_gaps);
    mfpe_req_t r;
    int        counted;
    write_update_enable(update);
    gaps_on = with_gaps;
    hot_x   = $urandom_range(0, PanelColumns - 4);
    hot_y   = $urandom_range(0, 8 * PanelPages - 10);
    counted = 0;
    while (counted < PhaseItems) begin
      r = random_request();
      issue_request(r, random_gap());
      if (!(r.mode == ModePut && is_off_panel(r))) counted++;
    end
    end_burst();
  endtask

  mfpe_req_t directed_q [$];

  initial begin
    rst_ni          = 1'b0;
    start           = 1'b0;
    req_i           = '0;
    cfg_we_i        = 1'b0;
    cfg_wdata_i     = 1'b0;
    put_count       = 0;
    get_count       = 0;
    off_panel_count = 0;
    cfg_count       = 0;
    gaps_on         = 1'b1;
    hot_x           = 0;
    hot_y           = 0;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);
    while (busy) @(negedge clk_i);

    write_update_enable(1'b1);
    directed_q = '{
      make_request(ModeGet, 0, 0, 1'b0),
      make_request(ModePut, 0, 0, 1'b1),
      make_request(ModeGet, 0, 0, 1'b0),
      make_request(ModePut, 191, 63, 1'b1),
      make_request(ModeGet, 191, 63, 1'b0),
      make_request(ModePut, 64, 8, 1'b1),
      make_request(ModePut, 63, 7, 1'b1),
      make_request(ModePut, 128, 0, 1'b1),
      make_request(ModePut, 127, 56, 1'b1),
      make_request(ModePut, 0, 0, 1'b0),
      make_request(ModeGet, 0, 0, 1'b1),
      make_request(ModePut, 192, 0, 1'b1),
      make_request(ModePut, 255, 127, 1'b1),
      make_request(ModeGet, 255, 127, 1'b1),
      make_request(ModeGet, 0, 64, 1'b0),
      make_request(ModePut, 5, 64, 1'b1),
      make_request(ModeGet, 191, 0, 1'b0),
      make_request(ModePut, 100, 33, 1'b1),
      make_request(ModePut, 100, 34, 1'b1),
      make_request(ModePut, 100, 33, 1'b0),
      make_request(ModeGet, 100, 34, 1'b0),
      make_request(ModeGet, 100, 33, 1'b0)
    };
    foreach (directed_q[i]) issue_request(directed_q[i], $urandom_range(0, 2));
    end_burst();

    run_random_phase(1'b0, 1'b1);
    run_random_phase(1'b1, 1'b0);
    run_random_phase(1'b0, 1'b0);
    run_random_phase(1'b1, 1'b1);

    wait_drained();
    repeat (20) @(negedge clk_i);
    $display("run covered %0d puts and %0d gets, %0d of them off the panel",
             put_count, get_count, off_panel_count);
    $display("update_enable written %0d times, write-through toggled off and on",
             cfg_count);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
